// ===== rtl/mml_pkg.sv =====
// Package for the mip level layout block: configuration, command and status types,
// field widths, size limits and the cube face tables.
// No dependencies; used by every module of the block.
package mml_pkg;

  localparam int MaxLevels      = 12;
  localparam int MaxTextureSize = 2048;

  localparam int LevelW = 4;
  localparam int PosXW  = 13;
  localparam int PosYW  = 14;
  localparam int DimW   = 12;
  localparam int PitchW = 13;
  localparam int TotalW = 24;
  localparam int SliceW = 25;
  localparam int CubeYW = 15;

  localparam int OutDataW = 136;
  localparam int InDataW  = 8;
  localparam int FaceW    = 3;
  localparam int AddrW    = 5;

  typedef enum logic [1:0] {
    MODE_2D   = 2'd0,
    MODE_CUBE = 2'd1,
    MODE_VOL  = 2'd2,
    MODE_RSVD = 2'd3
  } mml_mode_e;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_HEIGHT = 3'd2,
    REG_DEPTH  = 3'd3,
    REG_BPT    = 3'd4,
    REG_FIRST  = 3'd5,
    REG_LAST   = 3'd6,
    REG_COMP   = 3'd7
  } mml_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SETUP = 2'd1,
    ST_RUN   = 2'd2,
    ST_MUL   = 2'd3
  } mml_state_e;

  typedef struct packed {
    mml_mode_e         mode;
    logic [DimW-1:0]   base_w;
    logic [DimW-1:0]   base_h;
    logic [DimW-1:0]   base_d;
    logic [4:0]        bpt;
    logic [LevelW-1:0] first;
    logic [LevelW-1:0] last;
    logic              comp;
  } mml_cfg_t;

  typedef struct packed {
    logic load_face;
    logic init;
    logic emit;
    logic use_mul;
  } mml_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic vol_last;
    logic slot_free;
  } mml_status_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if ({1'b0, v} > (DimW+1)'(MaxTextureSize)) begin
      r = DimW'(MaxTextureSize);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [DimW-1:0] shrink(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v >> 1;
    if (r == '0) begin
      r = DimW'(1);
    end
    return r;
  endfunction

  // floor(r / cpp) for the pad r (0..3) added by 4-byte row rounding
  function automatic logic [1:0] pitch_extra(input logic [1:0] r, input logic [4:0] cpp);
    logic [1:0] q;
    if (cpp == 5'd1) begin
      q = r;
    end else if (cpp == 5'd2) begin
      q = r >> 1;
    end else if (cpp == 5'd3) begin
      q = (r == 2'd3) ? 2'd1 : 2'd0;
    end else begin
      q = 2'd0;
    end
    return q;
  endfunction

  function automatic logic face_start_x(input logic [2:0] f);
    logic r;
    unique case (f)
      3'd2, 3'd3, 3'd4, 3'd5: r = 1'b1;
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] face_start_y(input logic [2:0] f);
    logic [1:0] r;
    unique case (f)
      3'd1, 3'd3: r = 2'd2;
      3'd4:       r = 2'd1;
      3'd5:       r = 2'd3;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

  // x steps back by the new size on faces 2..5
  function automatic logic face_step_neg(input logic [2:0] f);
    logic r;
    unique case (f)
      3'd2, 3'd3, 3'd4, 3'd5: r = 1'b1;
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

  // y steps by twice the new size on faces 0..3, by the size on 4..5
  function automatic logic face_step_dbl(input logic [2:0] f);
    logic r;
    unique case (f)
      3'd4, 3'd5: r = 1'b0;
      default:    r = 1'b1;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/mml_regs.sv =====
// Configuration registers of the mip level layout block behind an APB-style port.
// Depends on mml_pkg.
module mml_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mml_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output mml_pkg::mml_cfg_t         cfg_o
);

  mml_pkg::mml_cfg_t cfg_q, cfg_d;
  mml_pkg::mml_reg_e idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = mml_pkg::mml_reg_e'(paddr[mml_pkg::AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        mml_pkg::REG_MODE:   cfg_d.mode   = mml_pkg::mml_mode_e'(pwdata[1:0]);
        mml_pkg::REG_WIDTH:  cfg_d.base_w = pwdata[mml_pkg::DimW-1:0];
        mml_pkg::REG_HEIGHT: cfg_d.base_h = pwdata[mml_pkg::DimW-1:0];
        mml_pkg::REG_DEPTH:  cfg_d.base_d = pwdata[mml_pkg::DimW-1:0];
        mml_pkg::REG_BPT:    cfg_d.bpt    = pwdata[4:0];
        mml_pkg::REG_FIRST:  cfg_d.first  = pwdata[mml_pkg::LevelW-1:0];
        mml_pkg::REG_LAST:   cfg_d.last   = pwdata[mml_pkg::LevelW-1:0];
        mml_pkg::REG_COMP:   cfg_d.comp   = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= mml_pkg::MODE_2D;
      cfg_q.base_w <= mml_pkg::DimW'(1);
      cfg_q.base_h <= mml_pkg::DimW'(1);
      cfg_q.base_d <= mml_pkg::DimW'(1);
      cfg_q.bpt    <= 5'd4;
      cfg_q.first  <= '0;
      cfg_q.last   <= '0;
      cfg_q.comp   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      mml_pkg::REG_MODE:   prdata = 32'(cfg_q.mode);
      mml_pkg::REG_WIDTH:  prdata = 32'(cfg_q.base_w);
      mml_pkg::REG_HEIGHT: prdata = 32'(cfg_q.base_h);
      mml_pkg::REG_DEPTH:  prdata = 32'(cfg_q.base_d);
      mml_pkg::REG_BPT:    prdata = 32'(cfg_q.bpt);
      mml_pkg::REG_FIRST:  prdata = 32'(cfg_q.first);
      mml_pkg::REG_LAST:   prdata = 32'(cfg_q.last);
      mml_pkg::REG_COMP:   prdata = 32'(cfg_q.comp);
      default:             prdata = '0;
    endcase
  end

endmodule

// ===== rtl/mml_dp.sv =====
// Datapath of the mip level layout block: level walk registers, pitch setup,
// volume products and the output item register.
// Depends on mml_pkg; driven by mml_ctrl commands.
module mml_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mml_pkg::mml_cfg_t            cfg_i,
  input  mml_pkg::mml_cmd_t            cmd_i,
  input  logic [mml_pkg::FaceW-1:0]    face_i,
  output mml_pkg::mml_status_t         status_o,
  input  logic                         out_tready_i,
  output logic                         out_tvalid_o,
  output logic [mml_pkg::OutDataW-1:0] out_tdata_o,
  output logic                         out_tlast_o
);

  localparam int DW = mml_pkg::DimW;
  localparam int TW = mml_pkg::TotalW;
  localparam int PW = mml_pkg::PitchW;
  localparam int YW = mml_pkg::CubeYW;
  localparam int LW = mml_pkg::LevelW;

  logic [mml_pkg::FaceW-1:0] face_q, face_sel;
  logic [LW-1:0]             lvl_q, lvl_d;
  logic [PW-1:0]             x_q, x_d;
  logic [YW-1:0]             y_q, y_d;
  logic [DW-1:0]             w_q, w_d, h_q, h_d, d_q, d_d;
  logic [TW-1:0]             total_q, total_d;
  logic [PW-1:0]             pitch_q, pitch_d;
  logic [TW+PW-1:0]          slice_prod_q;
  logic [TW+DW-1:0]          shown_prod_q;

  logic            is_cube, is_vol, is_comp2d;
  logic [DW-1:0]   bw, bh, bd, half;
  logic [4:0]      cpp;
  logic [LW-1:0]   hi;
  logic [PW-1:0]   wk;
  logic [3:0]      lo_prod;
  logic [1:0]      pad;
  logic [PW:0]     pitch_sum;
  logic [1:0]      iy;
  logic [DW:0]     rows;
  logic [TW:0]     total_sum;
  logic [TW-1:0]   total_new;
  logic            is_last;

  logic                   out_valid_q, out_valid_d;
  logic [LW-1:0]          o_lvl_q;
  logic [mml_pkg::PosXW-1:0] o_x_q;
  logic [mml_pkg::PosYW-1:0] o_y_q;
  logic [DW-1:0]          o_w_q, o_h_q, o_d_q;
  logic [PW-1:0]          o_pitch_q;
  logic [TW-1:0]          o_total_q;
  logic [mml_pkg::SliceW-1:0] o_slice_q;
  logic                   o_last_q;

  logic [mml_pkg::PosYW-1:0]  pos_y;
  logic [TW-1:0]              shown;
  logic [mml_pkg::SliceW-1:0] slice;

  assign is_cube   = (cfg_i.mode == mml_pkg::MODE_CUBE);
  assign is_vol    = (cfg_i.mode == mml_pkg::MODE_VOL);
  assign is_comp2d = !is_cube && !is_vol && cfg_i.comp;

  assign bw  = mml_pkg::clamp_dim(cfg_i.base_w);
  assign bh  = mml_pkg::clamp_dim(cfg_i.base_h);
  assign bd  = mml_pkg::clamp_dim(cfg_i.base_d);
  assign cpp = (cfg_i.bpt == '0) ? 5'd1 : cfg_i.bpt;
  assign hi  = (cfg_i.last > LW'(mml_pkg::MaxLevels - 1)) ? LW'(mml_pkg::MaxLevels - 1)
                                                          : cfg_i.last;

  assign face_sel = (face_q > 3'd5) ? 3'd0 : face_q;

  // pitch = row texels + the rounding pad expressed in whole texels
  assign wk        = is_cube ? {bw, 1'b0} : {1'b0, bw};
  assign lo_prod   = {2'b00, wk[1:0]} * {2'b00, cpp[1:0]};
  assign pad       = 2'd0 - lo_prod[1:0];
  assign pitch_sum = {1'b0, wk} + (PW+1)'(mml_pkg::pitch_extra(pad, cpp));
  assign iy        = mml_pkg::face_start_y(face_sel);

  assign half = w_q >> 1;

  always_comb begin
    if (is_comp2d) begin
      rows = (h_q[DW-1:2] == '0) ? (DW+1)'(1) : (DW+1)'(h_q >> 2);
    end else begin
      rows = (h_q < DW'(2)) ? (DW+1)'(2) : {1'b0, h_q};
    end
  end

  assign total_sum = {1'b0, total_q} + (TW+1)'(rows);
  assign total_new = total_sum[TW] ? '1 : total_sum[TW-1:0];
  assign is_last   = (lvl_q == hi);

  assign status_o.empty     = (cfg_i.first > hi);
  assign status_o.last      = is_last;
  assign status_o.vol_last  = is_vol && is_last;
  assign status_o.slot_free = !out_valid_q || out_tready_i;

  always_comb begin
    lvl_d   = lvl_q;
    x_d     = x_q;
    y_d     = y_q;
    w_d     = w_q;
    h_d     = h_q;
    d_d     = d_q;
    total_d = total_q;
    pitch_d = pitch_q;
    if (cmd_i.init) begin
      lvl_d   = cfg_i.first;
      w_d     = bw;
      h_d     = is_cube ? bw : bh;
      d_d     = bd;
      x_d     = mml_pkg::face_start_x(face_sel) ? {1'b0, bw} : '0;
      y_d     = (iy[1] ? {2'b00, bw, 1'b0} : '0) + (iy[0] ? {3'b000, bw} : '0);
      total_d = is_cube ? {{(TW-DW-2){1'b0}}, bw, 2'b00} : '0;
      pitch_d = pitch_sum[PW] ? '1 : pitch_sum[PW-1:0];
    end else if (cmd_i.emit) begin
      lvl_d = lvl_q + LW'(1);
      if (is_cube) begin
        if (half != '0) begin
          w_d = half;
          h_d = half;
          x_d = mml_pkg::face_step_neg(face_sel) ? x_q - PW'(half) : x_q;
          y_d = y_q + (mml_pkg::face_step_dbl(face_sel) ? YW'({half, 1'b0}) : YW'(half));
        end
      end else begin
        total_d = total_new;
        w_d     = mml_pkg::shrink(w_q);
        h_d     = mml_pkg::shrink(h_q);
        d_d     = mml_pkg::shrink(d_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_face) begin
      face_q <= face_i;
    end
    lvl_q        <= lvl_d;
    x_q          <= x_d;
    y_q          <= y_d;
    w_q          <= w_d;
    h_q          <= h_d;
    d_q          <= d_d;
    total_q      <= total_d;
    pitch_q      <= pitch_d;
    slice_prod_q <= (TW+PW)'(total_new) * (TW+PW)'(pitch_q);
    shown_prod_q <= (TW+DW)'(total_new) * (TW+DW)'(bd);
  end

  // output item fields
  always_comb begin
    if (is_cube) begin
      pos_y = y_q[YW-1] ? '1 : y_q[mml_pkg::PosYW-1:0];
    end else begin
      pos_y = (total_q[TW-1:mml_pkg::PosYW] != '0) ? '1 : total_q[mml_pkg::PosYW-1:0];
    end
    if (is_cube) begin
      shown = total_q;
    end else if (cmd_i.use_mul) begin
      shown = (shown_prod_q[TW+DW-1:TW] != '0) ? '1 : shown_prod_q[TW-1:0];
    end else begin
      shown = total_new;
    end
    if (cmd_i.use_mul) begin
      slice = (slice_prod_q[TW+PW-1:mml_pkg::SliceW] != '0) ? '1
            : slice_prod_q[mml_pkg::SliceW-1:0];
    end else begin
      slice = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      o_lvl_q   <= lvl_q;
      o_x_q     <= is_cube ? x_q : '0;
      o_y_q     <= pos_y;
      o_w_q     <= w_q;
      o_h_q     <= h_q;
      o_d_q     <= is_vol ? d_q : DW'(1);
      o_pitch_q <= pitch_q;
      o_total_q <= shown;
      o_slice_q <= slice;
      o_last_q  <= is_last;
    end
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tlast_o  = o_last_q;
  assign out_tdata_o  = {7'b0, o_slice_q, o_total_q, o_pitch_q, o_d_q, o_h_q, o_w_q,
                         o_y_q, o_x_q, o_lvl_q};

endmodule

// ===== rtl/mml_ctrl.sv =====
// Controller of the mip level layout block: takes a face item, runs setup,
// then steps the datapath once per level.
// Depends on mml_pkg.
module mml_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mml_pkg::mml_status_t status_i,
  output mml_pkg::mml_cmd_t    cmd_o
);

  mml_pkg::mml_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mml_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mml_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_face = 1'b1;
          state_d         = mml_pkg::ST_SETUP;
        end
      end
      mml_pkg::ST_SETUP: begin
        cmd_o.init = 1'b1;
        state_d    = status_i.empty ? mml_pkg::ST_IDLE : mml_pkg::ST_RUN;
      end
      mml_pkg::ST_RUN: begin
        priority if (status_i.vol_last) begin
          state_d = mml_pkg::ST_MUL;
        end else if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last) begin
            state_d = mml_pkg::ST_IDLE;
          end
        end
      end
      mml_pkg::ST_MUL: begin
        cmd_o.use_mul = 1'b1;
        if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = mml_pkg::ST_IDLE;
        end
      end
      default: state_d = mml_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/mipmap_level_layout.sv =====
// Mip level layout: for each face item taken on the input stream, one result item per
// mip level from the first configured level to the last (clamped to 11), giving position,
// size, row pitch, running total rows and, on the last volume level, slice pitch. An item
// passes an accept state, a setup state for the pitch and then one level per cycle from the
// level walk registers while the output does not stall, plus a product state on volume
// textures for the depth and slice products. An empty level range gives no result.
// Configuration must be written over the APB port while idle; the block does not enforce it.
// Depends on mml_pkg, mml_regs, mml_ctrl, mml_dp.
module mipmap_level_layout (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mml_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [2:0] face_index
  input  logic [mml_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [3:0] level_number, [16:4] pos_x, [30:17] pos_y, [42:31] img_width,
  // [54:43] image_height, [66:55] img_depth, [79:67] row_pitch,
  // [103:80] total_rows, [128:104] slice_pitch
  output logic [mml_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tlast
);

  mml_pkg::mml_cfg_t    cfg;
  mml_pkg::mml_cmd_t    cmd;
  mml_pkg::mml_status_t status;

  mml_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mml_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mml_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .face_i       (s_axis_tdata[mml_pkg::FaceW-1:0]),
    .status_o     (status),
    .out_tready_i (m_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .out_tdata_o  (m_axis_tdata),
    .out_tlast_o  (m_axis_tlast)
  );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for mipmap_level_layout: walks texture setups over APB and
// sends face items, predicting each level placement item and checking it.
// Depends on rtl/mml_pkg.sv and rtl/mipmap_level_layout.sv.
`timescale 1ns / 1ps

module tb_top;
  import mml_pkg::*;

  localparam int CycleLimit = 200000;
  localparam longint TotalMax = (64'd1 << TotalW) - 1;
  localparam longint SliceMax = (64'd1 << SliceW) - 1;

  typedef struct packed {
    logic              last;
    logic [SliceW-1:0] slice;
    logic [TotalW-1:0] total;
    logic [PitchW-1:0] pitch;
    logic [DimW-1:0]   d;
    logic [DimW-1:0]   h;
    logic [DimW-1:0]   w;
    logic [PosYW-1:0]  y;
    logic [PosXW-1:0]  x;
    logic [LevelW-1:0] lvl;
  } level_t;

  localparam int LevelBits = $bits(level_t) - 1;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;  // [2:0] face_index
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;      // level fields, lvl lowest; see level_t
  logic                m_axis_tlast;

  mipmap_level_layout dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  mml_cfg_t       cfg;
  logic [FaceW-1:0] face_q[$];
  level_t         level_q[$];
  level_t         got;
  level_t         want;
  logic           face_taken = 1'b0;
  logic           calm = 1'b0;
  int             layout_errors = 0;
  int             cycles = 0;

  int cube_x0 [6] = '{0, 0, 1, 1, 1, 1};
  int cube_y0 [6] = '{0, 2, 0, 2, 1, 3};
  int cube_dx [6] = '{0, 0, -1, -1, -1, -1};
  int cube_dy [6] = '{2, 2, 2, 2, 1, 1};

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic longint sat(input longint v, input longint m);
    return v < 0 ? 0 : (v > m ? m : v);
  endfunction

  function automatic longint fit_dim(input logic [DimW-1:0] v);
    return v == 0 ? 1 : (v > MaxTextureSize ? MaxTextureSize : longint'(v));
  endfunction

  function automatic longint halve(input longint v);
    return v < 2 ? 1 : v >> 1;
  endfunction

  function automatic void add_level(input longint lvl, x, y, w, h, d, pitch, total,
                                    slice, input bit last);
    level_t r;
    r.lvl   = LevelW'(lvl);
    r.x     = PosXW'(sat(x, (64'd1 << PosXW) - 1));
    r.y     = PosYW'(sat(y, (64'd1 << PosYW) - 1));
    r.w     = DimW'(sat(w, (64'd1 << DimW) - 1));
    r.h     = DimW'(sat(h, (64'd1 << DimW) - 1));
    r.d     = DimW'(sat(d, (64'd1 << DimW) - 1));
    r.pitch = PitchW'(sat(pitch, (64'd1 << PitchW) - 1));
    r.total = TotalW'(sat(total, TotalMax));
    r.slice = SliceW'(sat(slice, SliceMax));
    r.last  = last;
    level_q.push_back(r);
  endfunction

  // expected level items for one face item under the current texture setup
  function automatic void predict_levels(input logic [FaceW-1:0] face_in);
    longint w, h, d, d0, cpp, lo, hi, pitch, total, x, y, dim, rows, slice, shown, lvl;
    int f;
    bit vol;
    w   = fit_dim(cfg.base_w);
    h   = fit_dim(cfg.base_h);
    d   = fit_dim(cfg.base_d);
    d0  = d;
    cpp = cfg.bpt == 0 ? 1 : longint'(cfg.bpt);
    lo  = longint'(cfg.first);
    hi  = cfg.last > MaxLevels - 1 ? MaxLevels - 1 : longint'(cfg.last);
    if (lo > hi) return;
    if (cfg.mode == MODE_CUBE) begin
      f = face_in > 5 ? 0 : int'(face_in);
      pitch = ((w * cpp * 2 + 3) / 4) * 4 / cpp;
      dim = w;
      x = cube_x0[f] * w;
      y = cube_y0[f] * w;
      for (lvl = lo; lvl <= hi; lvl++) begin
        add_level(lvl, x, y, dim, dim, 1, pitch, w * 4, 0, lvl == hi);
        if ((dim >> 1) != 0) begin
          dim = dim >> 1;
          x += cube_dx[f] * dim;
          y += cube_dy[f] * dim;
        end
      end
    end else begin
      vol = cfg.mode == MODE_VOL;
      pitch = ((w * cpp + 3) / 4) * 4 / cpp;
      total = 0;
      for (lvl = lo; lvl <= hi; lvl++) begin
        y = total;
        if (!vol && cfg.comp) rows = h / 4 < 1 ? 1 : h / 4;
        else rows = h < 2 ? 2 : h;
        total = sat(total + rows, TotalMax);
        shown = total;
        slice = 0;
        if (vol && lvl == hi) begin
          slice = sat(total * pitch, SliceMax);
          shown = sat(total * d0, TotalMax);
        end
        add_level(lvl, 0, y, w, h, vol ? d : 1, pitch, shown, slice, lvl == hi);
        w = halve(w);
        h = halve(h);
        d = halve(d);
      end
    end
  endfunction

  task automatic report(input string what, input level_t exp_l, input level_t act_l);
    layout_errors++;
    if (layout_errors <= 10) begin
      $display("%s", what);
      $display("  exp lvl %0d x %0d y %0d w %0d h %0d d %0d pitch %0d total %0d slice %0d last %0d",
               exp_l.lvl, exp_l.x, exp_l.y, exp_l.w, exp_l.h, exp_l.d, exp_l.pitch,
               exp_l.total, exp_l.slice, exp_l.last);
      $display("  got lvl %0d x %0d y %0d w %0d h %0d d %0d pitch %0d total %0d slice %0d last %0d",
               act_l.lvl, act_l.x, act_l.y, act_l.w, act_l.h, act_l.d, act_l.pitch,
               act_l.total, act_l.slice, act_l.last);
    end
  endtask

  // face item driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || face_taken)) begin
      if (face_q.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= InDataW'(face_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= calm || $urandom_range(0, 99) >= 10;
  end

  // monitor and checker
  always @(posedge clk_i) begin
    face_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_levels(s_axis_tdata[FaceW-1:0]);
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tlast, m_axis_tdata[LevelBits-1:0]};
        if (level_q.size() == 0) begin
          report("level item with nothing expected", got, got);
        end else begin
          want = level_q.pop_front();
          if (got !== want) report("level item mismatch", want, got);
        end
      end
    end
  end

  task automatic reg_write(input mml_reg_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE:   cfg.mode   = mml_mode_e'(value[1:0]);
      REG_WIDTH:  cfg.base_w = value[DimW-1:0];
      REG_HEIGHT: cfg.base_h = value[DimW-1:0];
      REG_DEPTH:  cfg.base_d = value[DimW-1:0];
      REG_BPT:    cfg.bpt    = value[4:0];
      REG_FIRST:  cfg.first  = value[LevelW-1:0];
      REG_LAST:   cfg.last   = value[LevelW-1:0];
      REG_COMP:   cfg.comp   = value[0];
      default: ;
    endcase
  endtask

  task automatic set_texture(input mml_mode_e mode, input int w, h, d, bpt, first, last,
                             input bit comp);
    reg_write(REG_MODE, 32'(mode));
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_DEPTH, d);
    reg_write(REG_BPT, bpt);
    reg_write(REG_FIRST, first);
    reg_write(REG_LAST, last);
    reg_write(REG_COMP, 32'(comp));
  endtask

  // wait until every face item is taken and every level item is back
  task automatic settle();
    @(posedge clk_i);
    while (face_q.size() != 0 || s_axis_tvalid || level_q.size() != 0) @(posedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic int pick_size();
    int sel;
    int edges [6] = '{0, 1, 2, 2048, 2049, 4095};
    sel = $urandom_range(0, 2);
    if (sel == 0) return $urandom_range(1, 16);
    if (sel == 1) return $urandom_range(0, 4095);
    return edges[$urandom_range(0, 5)];
  endfunction

  initial begin
    int first, last;
    cfg = '{mode: MODE_2D, base_w: 1, base_h: 1, base_d: 1, bpt: 4, first: 0, last: 0,
            comp: 0};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset setup: a single 1x1 level
    face_q.push_back(0);
    face_q.push_back(7);
    settle();
    set_texture(MODE_2D, 2048, 2048, 1, 1, 0, 15, 0);
    face_q.push_back(2);
    settle();
    set_texture(MODE_2D, 1000, 7, 1, 3, 2, 11, 1);
    face_q.push_back(3);
    face_q.push_back(4);
    settle();
    set_texture(MODE_CUBE, 2048, 5, 9, 16, 0, 11, 0);
    for (int f = 0; f < 8; f++) face_q.push_back(FaceW'(f));
    settle();
    set_texture(MODE_CUBE, 1, 1, 1, 0, 0, 3, 1);
    face_q.push_back(5);
    face_q.push_back(6);
    settle();
    set_texture(MODE_VOL, 4095, 0, 2048, 31, 0, 11, 1);
    face_q.push_back(7);
    face_q.push_back(1);
    settle();
    // empty level ranges, plain and past the level bound, then a single volume level and a reserved-mode setup
    set_texture(MODE_RSVD, 3, 4095, 0, 2, 5, 3, 1);
    face_q.push_back(1);
    settle();
    set_texture(MODE_2D, 17, 33, 1, 5, 12, 15, 0);
    face_q.push_back(0);
    settle();
    set_texture(MODE_VOL, 5, 3, 7, 7, 11, 11, 0);
    face_q.push_back(4);
    settle();
    set_texture(MODE_RSVD, 63, 9, 4, 2, 0, 4, 1);
    face_q.push_back(2);
    settle();

    for (int phase = 0; phase < 14; phase++) begin
      if ($urandom_range(0, 4) != 0) begin
        first = $urandom_range(0, 11);
        last  = $urandom_range(first, 15);
      end else begin
        first = $urandom_range(0, 15);
        last  = $urandom_range(0, 15);
      end
      set_texture(mml_mode_e'($urandom_range(0, 3)), pick_size(), pick_size(), pick_size(),
                  $urandom_range(0, 31), first, last, 1'($urandom_range(0, 1)));
      calm = (phase == 6);
      for (int i = 0; i < 15; i++) face_q.push_back(FaceW'($urandom_range(0, 7)));
      settle();
    end
    calm = 1'b0;

    if (layout_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
